// File: rtl/assert_macros.svh
// Shared assertion macros for the decoder checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/ps2kd_pkg.sv
package ps2kd_pkg;

  localparam logic [7:0] PREFIX_E0 = 8'hE0;
  localparam logic [7:0] PREFIX_E1 = 8'hE1;
  localparam logic [7:0] FAKE_LSHIFT = 8'h2A;
  localparam logic [7:0] FAKE_RSHIFT = 8'h36;
  localparam logic [15:0] PAUSE_PAIR = 16'h451D;

  localparam logic [6:0] KEY_NONE   = 7'd0;
  localparam logic [6:0] KEY_CTRL   = 7'd29;
  localparam logic [6:0] KEY_SHIFT  = 7'd42;
  localparam logic [6:0] KEY_ALT    = 7'd56;
  localparam logic [6:0] KEY_CAPS   = 7'd58;
  localparam logic [6:0] KEY_NUM    = 7'd69;
  localparam logic [6:0] KEY_SCROLL = 7'd70;
  localparam logic [6:0] KEY_PAUSE  = 7'd119;

  localparam int OUT_BITS = 24;

  typedef enum logic [1:0] {
    E1_IDLE   = 2'd0,
    E1_FIRST  = 2'd1,
    E1_SECOND = 2'd2
  } ext1_phase_t;

  // Keycodes for E0-prefixed codes.
  function automatic logic [6:0] ext0_rom(input logic [6:0] code);
    logic [6:0] k;
    case (code)
      7'd29:   k = 7'd97;
      7'd56:   k = 7'd100;
      7'd71:   k = 7'd102;
      7'd72:   k = 7'd103;
      7'd73:   k = 7'd104;
      7'd75:   k = 7'd105;
      7'd77:   k = 7'd106;
      7'd79:   k = 7'd107;
      7'd80:   k = 7'd108;
      7'd81:   k = 7'd109;
      7'd82:   k = 7'd110;
      7'd83:   k = 7'd111;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  // Keycodes for plain codes.
  function automatic logic [6:0] base_rom(input logic [7:0] code);
    logic [6:0] k;
    if (code <= 8'd82) begin
      k = code[6:0];
    end else if (code == 8'd83) begin
      k = 7'd84;
    end else if (code >= 8'd86 && code <= 8'd88) begin
      k = code[6:0];
    end else begin
      k = KEY_NONE;
    end
    return k;
  endfunction

endpackage

// File: rtl/ps2_scancode_key_decoder.sv
// Data path: an accepted byte is held in the input register and is decoded
// into the result register once that register is empty or being taken; only
// bytes that yield a key put a key event on the output.
// Throughput: one scancode byte per cycle; the input stalls only while the
// result register holds an event that has not been taken.
// Reset: synchronous, active high; clears the decoder enable, prefix state,
// all modifier and lock flags, and both valid registers.
module ps2_scancode_key_decoder
  import ps2kd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] scan_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [6:0] key_code, [7] is_release, [8] shift_held, [9] ctrl_held,
  // [10] alt_held, [11] caps_lock_on, [12] num_lock_on, [13] scroll_lock_on,
  // [14] led_update, [17:15] led_bits, [23:18] zero
  output logic [OUT_BITS-1:0] m_axis_tdata
);

  logic        decoder_enable;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic [OUT_BITS-1:0] out_data;

  logic        ext0_pending, ext0_pending_next;
  ext1_phase_t ext1_phase, ext1_phase_next;
  logic [7:0]  ext1_first_byte, ext1_first_byte_next;
  logic        shift_flag, shift_flag_next;
  logic        ctrl_flag, ctrl_flag_next;
  logic        alt_flag, alt_flag_next;
  logic        caps_flag, caps_flag_next;
  logic        numlock_flag, numlock_flag_next;
  logic        scroll_flag, scroll_flag_next;

  ext1_phase_t phase;
  logic        brk;
  logic [7:0]  code;
  logic [6:0]  key;
  logic        led;
  logic [OUT_BITS-1:0] result;
  logic        advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Prefix tracking and code translation.
  always_comb begin
    case (ext1_phase)
      E1_FIRST:  phase = E1_FIRST;
      E1_SECOND: phase = E1_SECOND;
      default:   phase = E1_IDLE;
    endcase
    // A prefix byte is not a break code only when its own prefix is not pending.
    brk = in_byte[7] && (phase != E1_IDLE || in_byte != PREFIX_E1) &&
          (ext0_pending || in_byte != PREFIX_E0);
    code = brk ? {1'b0, in_byte[6:0]} : in_byte;

    key                  = KEY_NONE;
    ext0_pending_next    = ext0_pending;
    ext1_phase_next      = phase;
    ext1_first_byte_next = ext1_first_byte;

    if (ext0_pending) begin
      // Fake shifts map to no key in the E0 table, so they are swallowed.
      ext0_pending_next = 1'b0;
      if (code != FAKE_LSHIFT && code != FAKE_RSHIFT) begin
        key = ext0_rom(code[6:0]);
      end
    end else begin
      case (phase)
        E1_SECOND: begin
          key = ({code, ext1_first_byte} == PAUSE_PAIR) ? KEY_PAUSE : KEY_NONE;
          ext1_phase_next = E1_IDLE;
        end
        E1_FIRST: begin
          ext1_first_byte_next = code;
          ext1_phase_next      = E1_SECOND;
        end
        default: begin
          if (code == PREFIX_E0) begin
            ext0_pending_next = 1'b1;
          end else if (code == PREFIX_E1) begin
            ext1_phase_next = E1_FIRST;
          end else begin
            key = base_rom(code);
          end
        end
      endcase
    end
  end

  // Modifier and lock updates and the result word.
  always_comb begin
    shift_flag_next   = shift_flag;
    ctrl_flag_next    = ctrl_flag;
    alt_flag_next     = alt_flag;
    caps_flag_next    = caps_flag;
    numlock_flag_next = numlock_flag;
    scroll_flag_next  = scroll_flag;
    led               = 1'b0;
    if (brk) begin
      case (key)
        KEY_SHIFT: shift_flag_next = 1'b0;
        KEY_CTRL:  ctrl_flag_next  = 1'b0;
        KEY_ALT:   alt_flag_next   = 1'b0;
        default:   ;
      endcase
    end else begin
      case (key)
        KEY_SHIFT:  shift_flag_next = 1'b1;
        KEY_CTRL:   ctrl_flag_next  = 1'b1;
        KEY_ALT:    alt_flag_next   = 1'b1;
        KEY_CAPS: begin
          caps_flag_next = !caps_flag;
          led            = 1'b1;
        end
        KEY_NUM: begin
          numlock_flag_next = !numlock_flag;
          led               = 1'b1;
        end
        KEY_SCROLL: begin
          scroll_flag_next = !scroll_flag;
          led              = 1'b1;
        end
        default: ;
      endcase
    end
    result = {6'd0,
              led ? {caps_flag_next, numlock_flag_next, scroll_flag_next} : 3'd0,
              led, scroll_flag_next, numlock_flag_next, caps_flag_next,
              alt_flag_next, ctrl_flag_next, shift_flag_next, brk, key};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decoder_enable  <= 1'b0;
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      ext0_pending    <= 1'b0;
      ext1_phase      <= E1_IDLE;
      ext1_first_byte <= 8'd0;
      shift_flag      <= 1'b0;
      ctrl_flag       <= 1'b0;
      alt_flag        <= 1'b0;
      caps_flag       <= 1'b0;
      numlock_flag    <= 1'b0;
      scroll_flag     <= 1'b0;
    end else begin
      if (cfg_we) begin
        decoder_enable <= cfg_wdata;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      // A disabled decoder drops the byte with no effect on state.
      if (advance && decoder_enable) begin
        ext0_pending    <= ext0_pending_next;
        ext1_phase      <= ext1_phase_next;
        ext1_first_byte <= ext1_first_byte_next;
        if (key != KEY_NONE) begin
          shift_flag   <= shift_flag_next;
          ctrl_flag    <= ctrl_flag_next;
          alt_flag     <= alt_flag_next;
          caps_flag    <= caps_flag_next;
          numlock_flag <= numlock_flag_next;
          scroll_flag  <= scroll_flag_next;
        end
      end
      if (advance && decoder_enable && key != KEY_NONE) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
    if (advance && decoder_enable && key != KEY_NONE) begin
      out_data <= result;
    end
  end

endmodule

// File: rtl/ps2kd_checker.sv
`include "assert_macros.svh"

module ps2kd_checker
  import ps2kd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_BITS-1:0] m_axis_tdata
);

  // A stalled result keeps its value.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Every delivered event has a real keycode.
  `ASSERT_IMPLY(a_key_nonzero, clk, rst, m_axis_tvalid, m_axis_tdata[6:0] != 7'd0)

  // The LED field mirrors the lock flags when an update is requested:
  // caps on bit 2, num on bit 1, scroll on bit 0.
  `ASSERT_IMPLY(a_led_match, clk, rst, m_axis_tvalid && m_axis_tdata[14], (m_axis_tdata[17] == m_axis_tdata[11]) && (m_axis_tdata[16] == m_axis_tdata[12]) && (m_axis_tdata[15] == m_axis_tdata[13]))

  // Without an update request the LED field is zero.
  `ASSERT_IMPLY(a_led_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[14], m_axis_tdata[17:15] == 3'd0)

  // Locks toggle on make codes only.
  `ASSERT_IMPLY(a_led_make, clk, rst, m_axis_tvalid && m_axis_tdata[14], !m_axis_tdata[7])

endmodule

bind ps2_scancode_key_decoder ps2kd_checker u_ps2kd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: dv/ps2_scancode_key_decoder_checker.sv
`timescale 1ns / 1ps

module ps2_scancode_key_decoder_checker
  import ps2kd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OUT_BITS-1:0] m_axis_tdata,
  output int                  pending_events,
  output int                  mismatch_count
);

  localparam int PRINT_LIMIT = 60;

  typedef struct packed {
    logic [5:0] pad;
    logic [2:0] led_bits;
    logic       led_update;
    logic       scroll_lock_on;
    logic       num_lock_on;
    logic       caps_lock_on;
    logic       alt_held;
    logic       ctrl_held;
    logic       shift_held;
    logic       is_release;
    logic [6:0] key_code;
  } key_event_t;

  // Predicted decoder state.
  logic        decoder_on;
  logic        e0_pending;
  ext1_phase_t e1_phase;
  logic [7:0]  e1_first;
  logic        shift_on, ctrl_on, alt_on;
  logic        caps_on, num_on, scroll_on;

  key_event_t  expected_events[$];
  key_event_t  new_event, got_event, want_event;

  function automatic logic [6:0] extended_keycode(input logic [6:0] code);
    case (code)
      7'h1D: return 7'd97;
      7'h38: return 7'd100;
      7'h47: return 7'd102;
      7'h48: return 7'd103;
      7'h49: return 7'd104;
      7'h4B: return 7'd105;
      7'h4D: return 7'd106;
      7'h4F: return 7'd107;
      7'h50: return 7'd108;
      7'h51: return 7'd109;
      7'h52: return 7'd110;
      7'h53: return 7'd111;
      default: return KEY_NONE;
    endcase
  endfunction

  function automatic logic [6:0] plain_keycode(input logic [7:0] code);
    if (code <= 8'h52) return code[6:0];
    if (code == 8'h53) return 7'd84;
    if (code >= 8'h56 && code <= 8'h58) return code[6:0];
    return KEY_NONE;
  endfunction

  // Advances the predicted state by one scancode byte; returns 1 when a key event results.
  function automatic bit decode_scan_byte(input logic [7:0] raw, output key_event_t ev);
    logic [7:0] code;
    logic [6:0] key;
    logic       brk;
    logic       led;
    code = raw;
    key  = KEY_NONE;
    brk  = 1'b0;
    led  = 1'b0;
    ev   = '0;
    if (!decoder_on) return 0;

    // A prefix byte is exempt from break decoding only while its own prefix is not pending.
    if (code[7] && (e1_phase != E1_IDLE || code != PREFIX_E1) &&
        (e0_pending || code != PREFIX_E0)) begin
      brk     = 1'b1;
      code[7] = 1'b0;
    end

    if (e0_pending) begin
      e0_pending = 1'b0;
      if (code == FAKE_LSHIFT || code == FAKE_RSHIFT) return 0;
      key = extended_keycode(code[6:0]);
    end else if (e1_phase == E1_SECOND) begin
      key      = ({code, e1_first} == PAUSE_PAIR) ? KEY_PAUSE : KEY_NONE;
      e1_phase = E1_IDLE;
    end else if (e1_phase == E1_FIRST) begin
      e1_first = code;
      e1_phase = E1_SECOND;
    end else if (code == PREFIX_E0) begin
      e0_pending = 1'b1;
    end else if (code == PREFIX_E1) begin
      e1_phase = E1_FIRST;
    end else begin
      key = plain_keycode(code);
    end

    if (key == KEY_NONE) return 0;

    if (brk) begin
      if (key == KEY_SHIFT) shift_on = 1'b0;
      else if (key == KEY_CTRL) ctrl_on = 1'b0;
      else if (key == KEY_ALT) alt_on = 1'b0;
    end else begin
      case (key)
        KEY_SHIFT:  shift_on = 1'b1;
        KEY_CTRL:   ctrl_on = 1'b1;
        KEY_ALT:    alt_on = 1'b1;
        KEY_CAPS:   begin caps_on = ~caps_on; led = 1'b1; end
        KEY_NUM:    begin num_on = ~num_on; led = 1'b1; end
        KEY_SCROLL: begin scroll_on = ~scroll_on; led = 1'b1; end
        default: ;
      endcase
    end

    ev.key_code       = key;
    ev.is_release     = brk;
    ev.shift_held     = shift_on;
    ev.ctrl_held      = ctrl_on;
    ev.alt_held       = alt_on;
    ev.caps_lock_on   = caps_on;
    ev.num_lock_on    = num_on;
    ev.scroll_lock_on = scroll_on;
    ev.led_update     = led;
    ev.led_bits       = led ? {caps_on, num_on, scroll_on} : 3'd0;
    return 1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      decoder_on = 1'b0;
      e0_pending = 1'b0;
      e1_phase   = E1_IDLE;
      e1_first   = 8'h00;
      shift_on   = 1'b0;
      ctrl_on    = 1'b0;
      alt_on     = 1'b0;
      caps_on    = 1'b0;
      num_on     = 1'b0;
      scroll_on  = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg_we) decoder_on = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_scan_byte(s_axis_tdata, new_event)) expected_events.push_back(new_event);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_event = m_axis_tdata;
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("key event %h arrived with none expected", m_axis_tdata));
        end else begin
          want_event = expected_events.pop_front();
          check_field("key_code", got_event.key_code, want_event.key_code);
          check_field("is_release", got_event.is_release, want_event.is_release);
          check_field("shift_held", got_event.shift_held, want_event.shift_held);
          check_field("ctrl_held", got_event.ctrl_held, want_event.ctrl_held);
          check_field("alt_held", got_event.alt_held, want_event.alt_held);
          check_field("caps_lock_on", got_event.caps_lock_on, want_event.caps_lock_on);
          check_field("num_lock_on", got_event.num_lock_on, want_event.num_lock_on);
          check_field("scroll_lock_on", got_event.scroll_lock_on,
                      want_event.scroll_lock_on);
          check_field("led_update", got_event.led_update, want_event.led_update);
          check_field("led_bits", got_event.led_bits, want_event.led_bits);
          check_field("padding", got_event.pad, want_event.pad);
        end
      end
    end
    pending_events <= expected_events.size();
  end

endmodule

// File: dv/ps2_scancode_key_decoder_tb.sv
`timescale 1ns / 1ps

module ps2_scancode_key_decoder_tb;
  import ps2kd_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 6;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;

  int   pending_events;
  int   mismatch_count;
  int   burst_left = 0;
  bit   steady_sender = 1'b0;
  int   stuck_cycles = 0;
  int   rx_cycle = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;

  ps2_scancode_key_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ps2_scancode_key_decoder_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .pending_events (pending_events),
    .mismatch_count (mismatch_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver cycles through its own stall patterns. A toggle of hold_req
  // starts one long hold-off that this process counts down by itself.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 100) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 4) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", STUCK_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_scan_byte(input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Waits until every expected key event has been taken, then lets the pipeline settle.
  task automatic drain_events();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed key sequences with random content, plus raw noise bytes.
  task automatic send_random_traffic(input int n_bytes);
    int         sent;
    int         kind;
    logic       brk;
    logic [6:0] code;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(0, 99);
      brk  = 1'($urandom_range(0, 1));
      if (kind < 15) begin
        push_scan_byte(8'($urandom_range(0, 255)));
        sent += 1;
      end else if (kind < 35) begin
        case ($urandom_range(0, 5))
          0: code = 7'h2A;
          1: code = 7'h1D;
          2: code = 7'h38;
          3: code = 7'h3A;
          4: code = 7'h45;
          default: code = 7'h46;
        endcase
        push_scan_byte({brk, code});
        sent += 1;
      end else if (kind < 50) begin
        case ($urandom_range(0, 12))
          0: code = 7'h1D;
          1: code = 7'h38;
          2: code = 7'h47;
          3: code = 7'h48;
          4: code = 7'h49;
          5: code = 7'h4B;
          6: code = 7'h4D;
          7: code = 7'h4F;
          8: code = 7'h50;
          9: code = 7'h51;
          10: code = 7'h52;
          11: code = 7'h53;
          default: code = 7'($urandom_range(0, 127));
        endcase
        push_scan_byte(PREFIX_E0);
        push_scan_byte({brk, code});
        sent += 2;
      end else if (kind < 55) begin
        push_scan_byte(PREFIX_E0);
        push_scan_byte($urandom_range(0, 1) ? {brk, FAKE_LSHIFT[6:0]} : {brk, FAKE_RSHIFT[6:0]});
        sent += 2;
      end else if (kind < 63) begin
        push_scan_byte(PREFIX_E1);
        if ($urandom_range(0, 4) < 3) begin
          push_scan_byte({brk, PAUSE_PAIR[6:0]});
          push_scan_byte({brk, PAUSE_PAIR[14:8]});
        end else begin
          push_scan_byte(8'($urandom_range(0, 255)));
          push_scan_byte(8'($urandom_range(0, 255)));
        end
        sent += 3;
      end else begin
        push_scan_byte({brk, 7'($urandom_range(1, 8'h58))});
        sent += 1;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Disabled: every byte must vanish without a key event.
    write_enable(1'b0);
    send_random_traffic(20);
    drain_events();

    write_enable(1'b1);
    // Plain make and break, modifiers, lock toggles, the extended keys and the
    // fake shifts, the pause sequence both ways, prefixes while prefixed,
    // and the edges of the byte range.
    push_scan_byte(8'h1E);
    push_scan_byte(8'h9E);
    push_scan_byte(8'h2A);
    push_scan_byte(8'hAA);
    push_scan_byte(8'h1D);
    push_scan_byte(8'h38);
    push_scan_byte(8'h3A);
    push_scan_byte(8'h3A);
    push_scan_byte(8'hBA);
    push_scan_byte(8'h45);
    push_scan_byte(8'h46);
    push_scan_byte(PREFIX_E0);
    push_scan_byte(8'h1D);
    push_scan_byte(PREFIX_E0);
    push_scan_byte(8'h9D);
    push_scan_byte(PREFIX_E0);
    push_scan_byte(FAKE_LSHIFT);
    push_scan_byte(PREFIX_E0);
    push_scan_byte(8'hB6);
    push_scan_byte(PREFIX_E1);
    push_scan_byte(8'h1D);
    push_scan_byte(8'h45);
    push_scan_byte(PREFIX_E1);
    push_scan_byte(8'h9D);
    push_scan_byte(8'hC5);
    push_scan_byte(PREFIX_E0);
    push_scan_byte(PREFIX_E0);
    push_scan_byte(PREFIX_E1);
    push_scan_byte(PREFIX_E1);
    push_scan_byte(8'h00);
    push_scan_byte(8'hFF);
    push_scan_byte(8'h53);
    drain_events();

    send_random_traffic(700);
    drain_events();

    // Long receiver hold-off while the sender keeps offering make codes.
    steady_sender = 1'b1;
    hold_req <= ~hold_req;
    for (int n = 0; n < 60; n++) push_scan_byte(8'h02 + n[7:0]);
    drain_events();
    steady_sender = 1'b0;

    write_enable(1'b0);
    send_random_traffic(30);
    drain_events();

    write_enable(1'b1);
    send_random_traffic(1000);
    drain_events();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
